[rtl/argb_cmyk_converter_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for argb_cmyk_converter_unit
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARGB_CMYK_CONVERTER_UNIT_ASSERT_SVH
`define ARGB_CMYK_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ACC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ACC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/acc_pkg.sv]
// ----------------------------------------------------------------------------
// acc_pkg
// Types, constants and helper functions of the ARGB/CMYK converter.
// ----------------------------------------------------------------------------
package acc_pkg;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned LANES  = 3;
	localparam int unsigned NCELLS = WORD_W;

	localparam logic [WORD_W-1:0] FULL = 16'hFFFF;

	localparam logic KIND_TO_CMYK = 1'b0;
	localparam logic KIND_TO_ARGB = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	// Division state carried down the cell chain.
	typedef struct packed {
		logic [LANES-1:0][WORD_W-1:0] rem;
		logic [LANES-1:0][WORD_W-1:0] low;
		logic [LANES-1:0][WORD_W-1:0] quo;
		logic [WORD_W-1:0]            den;
	} div_t;

	// Side information that rides along with the division.
	typedef struct packed {
		logic                         kind;
		logic                         black;
		logic [WORD_W-1:0]            k;
		logic [LANES-1:0][WORD_W-1:0] ink;
	} side_t;

	// Exact floor(p / 65535) for p <= 65535 * 65535.
	function automatic word_t div_full(input logic [2*WORD_W-1:0] p);
		logic [WORD_W:0] q0;
		logic [WORD_W:0] r;
		logic [WORD_W:0] q;
		q0 = {1'b0, p[2*WORD_W-1:WORD_W]};
		r  = {1'b0, p[WORD_W-1:0]} + q0;
		if (r >= {FULL, 1'b0}) begin
			q = q0 + 17'd2;
		end else if (r >= {1'b0, FULL}) begin
			q = q0 + 17'd1;
		end else begin
			q = q0;
		end
		return q[WORD_W-1:0];
	endfunction

endpackage

[rtl/acc_div_cell.sv]
// ----------------------------------------------------------------------------
// acc_div_cell
// One restoring-division step: resolves one quotient bit for each lane.
// ----------------------------------------------------------------------------
`include "argb_cmyk_converter_unit_assert.svh"

module acc_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  acc_pkg::div_t in_div,
	input  acc_pkg::side_t in_side,
	output logic          in_stall,
	output logic          out_valid,
	output acc_pkg::div_t out_div,
	output acc_pkg::side_t out_side,
	input  logic          out_stall
);

	logic          valid_q;
	logic          hold;
	acc_pkg::div_t div_q;
	acc_pkg::side_t side_q;
	acc_pkg::div_t div_n;

	assign hold     = valid_q & out_stall;
	assign in_stall = hold;

	always_comb begin
		logic [acc_pkg::WORD_W:0] trial;
		logic [acc_pkg::WORD_W:0] diff;
		logic                     qbit;
		div_n     = in_div;
		trial     = '0;
		diff      = '0;
		qbit      = 1'b0;
		for (int i = 0; i < acc_pkg::LANES; i++) begin
			trial = {in_div.rem[i], in_div.low[i][acc_pkg::WORD_W-1]};
			diff  = trial - {1'b0, in_div.den};
			qbit  = ~diff[acc_pkg::WORD_W];
			div_n.rem[i] = qbit ? diff[acc_pkg::WORD_W-1:0] : trial[acc_pkg::WORD_W-1:0];
			div_n.low[i] = {in_div.low[i][acc_pkg::WORD_W-2:0], 1'b0};
			div_n.quo[i] = {in_div.quo[i][acc_pkg::WORD_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!hold) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			div_q  <= div_n;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_div   = div_q;
	assign out_side  = side_q;

	`ACC_ASSERT_NOW(a_den_nonzero, valid_q, div_q.den != '0, "zero divisor in cell")
	`ACC_ASSERT_NOW(a_rem_bound, valid_q, (div_q.rem[0] < div_q.den) && (div_q.rem[1] < div_q.den) && (div_q.rem[2] < div_q.den), "remainder not below divisor")
	`ACC_ASSERT_NEXT(a_hold_keeps, hold, valid_q && $stable(div_q) && $stable(side_q), "stalled cell changed")

endmodule

[rtl/acc_front.sv]
// ----------------------------------------------------------------------------
// acc_front
// Multiply, scale by 1/65535, pick black and build the division operands.
// ----------------------------------------------------------------------------
module acc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           kind,
	input  acc_pkg::word_t word_0,
	input  acc_pkg::word_t word_1,
	input  acc_pkg::word_t word_2,
	input  acc_pkg::word_t word_3,
	output logic           in_stall,
	output logic           out_valid,
	output acc_pkg::div_t  out_div,
	output acc_pkg::side_t out_side,
	input  logic           out_stall
);

	logic v_s1, v_s2, v_s3;
	logic hold1, hold2, hold3;

	logic [acc_pkg::LANES-1:0][2*acc_pkg::WORD_W-1:0] prod_s1;
	logic           kind_s1;
	acc_pkg::word_t k_s1;

	logic [acc_pkg::LANES-1:0][acc_pkg::WORD_W-1:0] val_s2;
	logic           kind_s2;

	acc_pkg::div_t  div_s3;
	acc_pkg::side_t side_s3;

	logic [acc_pkg::LANES-1:0][2*acc_pkg::WORD_W-1:0] prod_n;
	logic [acc_pkg::LANES-1:0][acc_pkg::WORD_W-1:0]   val_n;
	acc_pkg::div_t  div_n;
	acc_pkg::side_t side_n;

	assign hold3    = v_s3 & out_stall;
	assign hold2    = v_s2 & hold3;
	assign hold1    = v_s1 & hold2;
	assign in_stall = hold1;

	// Stage 1: one 16x16 product per lane, operands chosen by kind.
	always_comb begin
		acc_pkg::word_t opb;
		acc_pkg::word_t x0;
		acc_pkg::word_t x1;
		acc_pkg::word_t x2;
		opb = (kind == acc_pkg::KIND_TO_ARGB) ? ~word_3 : word_0;
		if (kind == acc_pkg::KIND_TO_ARGB) begin
			x0 = word_0;
			x1 = word_1;
			x2 = word_2;
		end else begin
			x0 = word_1;
			x1 = word_2;
			x2 = word_3;
		end
		prod_n[0] = {{acc_pkg::WORD_W{1'b0}}, x0} * {{acc_pkg::WORD_W{1'b0}}, opb};
		prod_n[1] = {{acc_pkg::WORD_W{1'b0}}, x1} * {{acc_pkg::WORD_W{1'b0}}, opb};
		prod_n[2] = {{acc_pkg::WORD_W{1'b0}}, x2} * {{acc_pkg::WORD_W{1'b0}}, opb};
	end

	// Stage 2: scale down, add k when converting to ARGB, and invert.
	always_comb begin
		acc_pkg::word_t q;
		q = '0;
		for (int i = 0; i < acc_pkg::LANES; i++) begin
			q = acc_pkg::div_full(prod_s1[i]);
			if (kind_s1 == acc_pkg::KIND_TO_ARGB) begin
				val_n[i] = acc_pkg::FULL - (q + k_s1);
			end else begin
				val_n[i] = acc_pkg::FULL - q;
			end
		end
	end

	// Stage 3: black, divisor and numerators.
	always_comb begin
		acc_pkg::word_t kmin;
		acc_pkg::word_t d;
		logic [2*acc_pkg::WORD_W-1:0] num;
		kmin = val_s2[0];
		if (val_s2[1] < kmin) kmin = val_s2[1];
		if (val_s2[2] < kmin) kmin = val_s2[2];
		d   = '0;
		num = '0;
		div_n        = '0;
		side_n       = '0;
		side_n.kind  = kind_s2;
		div_n.den    = acc_pkg::word_t'(1);
		if (kind_s2 == acc_pkg::KIND_TO_ARGB) begin
			side_n.ink = val_s2;
		end else begin
			side_n.k     = kmin;
			side_n.black = (kmin == acc_pkg::FULL);
			if (kmin != acc_pkg::FULL) begin
				div_n.den = acc_pkg::FULL - kmin;
				for (int i = 0; i < acc_pkg::LANES; i++) begin
					d   = val_s2[i] - kmin;
					num = {d, {acc_pkg::WORD_W{1'b0}}} - {{acc_pkg::WORD_W{1'b0}}, d};
					div_n.rem[i] = num[2*acc_pkg::WORD_W-1:acc_pkg::WORD_W];
					div_n.low[i] = num[acc_pkg::WORD_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (!hold1) v_s1 <= in_valid;
			if (!hold2) v_s2 <= v_s1;
			if (!hold3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold1) begin
			prod_s1 <= prod_n;
			kind_s1 <= kind;
			k_s1    <= word_3;
		end
		if (!hold2) begin
			val_s2  <= val_n;
			kind_s2 <= kind_s1;
		end
		if (!hold3) begin
			div_s3  <= div_n;
			side_s3 <= side_n;
		end
	end

	assign out_valid = v_s3;
	assign out_div   = div_s3;
	assign out_side  = side_s3;

endmodule

[rtl/argb_cmyk_converter_unit.sv]
// ----------------------------------------------------------------------------
// argb_cmyk_converter_unit
// Converts one 16-bit-per-channel pixel between ARGB and CMYK per transaction.
// ----------------------------------------------------------------------------
// Pipeline: 3 front stages, 16 division cells, 1 output register.
// Throughput: one transaction per cycle while the consumer does not stall;
//   each division cell resolves one quotient bit, so the 16-cell chain sets
//   the latency, not the rate.
// Reset: arst_n clears all valid flags at once; payload registers are not reset.
module argb_cmyk_converter_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           kind,
	input  acc_pkg::word_t word_0,
	input  acc_pkg::word_t word_1,
	input  acc_pkg::word_t word_2,
	input  acc_pkg::word_t word_3,
	output logic           out_valid,
	input  logic           out_stall,
	output acc_pkg::word_t out_0,
	output acc_pkg::word_t out_1,
	output acc_pkg::word_t out_2,
	output acc_pkg::word_t out_3
);

	// Chain links: index i feeds cell i, index NCELLS leaves the last cell.
	logic           v   [acc_pkg::NCELLS+1];
	logic           st  [acc_pkg::NCELLS+1];
	acc_pkg::div_t  dv  [acc_pkg::NCELLS+1];
	acc_pkg::side_t sd  [acc_pkg::NCELLS+1];

	logic           out_valid_q;
	logic           out_hold;
	acc_pkg::word_t out0_q, out1_q, out2_q, out3_q;

	// Premultiply, invert, pick black and prepare the long division.
	acc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.word_0    (word_0),
		.word_1    (word_1),
		.word_2    (word_2),
		.word_3    (word_3),
		.in_stall  (in_stall),
		.out_valid (v[0]),
		.out_div   (dv[0]),
		.out_side  (sd[0]),
		.out_stall (st[0])
	);

	// One quotient bit per cell, all three lanes in parallel.
	for (genvar i = 0; i < acc_pkg::NCELLS; i++) begin : g_cell
		acc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[i]),
			.in_div    (dv[i]),
			.in_side   (sd[i]),
			.in_stall  (st[i]),
			.out_valid (v[i+1]),
			.out_div   (dv[i+1]),
			.out_side  (sd[i+1]),
			.out_stall (st[i+1])
		);
	end

	// Output register: hold while the consumer stalls, otherwise advance.
	assign out_hold                = out_valid_q & out_stall;
	assign st[acc_pkg::NCELLS]     = out_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_hold) begin
			out_valid_q <= v[acc_pkg::NCELLS];
		end
	end

	// Select the final channel values: opaque ARGB, pure black, or quotients.
	always_ff @(posedge clk) begin
		if (!out_hold) begin
			if (sd[acc_pkg::NCELLS].kind == acc_pkg::KIND_TO_ARGB) begin
				out0_q <= acc_pkg::FULL;
				out1_q <= sd[acc_pkg::NCELLS].ink[0];
				out2_q <= sd[acc_pkg::NCELLS].ink[1];
				out3_q <= sd[acc_pkg::NCELLS].ink[2];
			end else if (sd[acc_pkg::NCELLS].black) begin
				out0_q <= '0;
				out1_q <= '0;
				out2_q <= '0;
				out3_q <= acc_pkg::FULL;
			end else begin
				out0_q <= dv[acc_pkg::NCELLS].quo[0];
				out1_q <= dv[acc_pkg::NCELLS].quo[1];
				out2_q <= dv[acc_pkg::NCELLS].quo[2];
				out3_q <= sd[acc_pkg::NCELLS].k;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_0     = out0_q;
	assign out_1     = out1_q;
	assign out_2     = out2_q;
	assign out_3     = out3_q;

endmodule

[tb/argb_cmyk_converter_checker.sv]
// ----------------------------------------------------------------------------
// argb_cmyk_converter_checker
// Watches both channels of the converter, predicts each result from the
// accepted pixel with exact integer arithmetic, and compares in order.
// ----------------------------------------------------------------------------
module argb_cmyk_converter_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  logic           kind,
	input  acc_pkg::word_t word_0,
	input  acc_pkg::word_t word_1,
	input  acc_pkg::word_t word_2,
	input  acc_pkg::word_t word_3,
	input  logic           out_valid,
	input  logic           out_stall,
	input  acc_pkg::word_t out_0,
	input  acc_pkg::word_t out_1,
	input  acc_pkg::word_t out_2,
	input  acc_pkg::word_t out_3,
	output int             fail_count,
	output int             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef acc_pkg::word_t word_t;

	localparam word_t FULL         = acc_pkg::FULL;
	localparam logic  KIND_TO_CMYK = acc_pkg::KIND_TO_CMYK;

	typedef struct packed {
		word_t w0;
		word_t w1;
		word_t w2;
		word_t w3;
	} pixel_t;

	pixel_t expected_pixels[$];

	assign pending = expected_pixels.size();

	// floor(x * y / 65535) with wide operands
	function automatic longint unsigned scale_full(longint unsigned x, longint unsigned y);
		return (x * y) / 65535;
	endfunction

	function automatic pixel_t convert_pixel(logic k_in, word_t a, word_t b, word_t c, word_t d);
		pixel_t          res;
		longint unsigned cc, mm, yy, kk;
		if (k_in == KIND_TO_CMYK) begin
			cc = 65535 - scale_full(b, a);
			mm = 65535 - scale_full(c, a);
			yy = 65535 - scale_full(d, a);
			kk = cc;
			if (mm < kk) kk = mm;
			if (yy < kk) kk = yy;
			if (kk == 65535) begin
				res = '{16'd0, 16'd0, 16'd0, FULL};
			end else begin
				res.w0 = word_t'(((cc - kk) * 65535) / (65535 - kk));
				res.w1 = word_t'(((mm - kk) * 65535) / (65535 - kk));
				res.w2 = word_t'(((yy - kk) * 65535) / (65535 - kk));
				res.w3 = word_t'(kk);
			end
		end else begin
			res.w0 = FULL;
			res.w1 = word_t'(65535 - (scale_full(a, 65535 - d) + d));
			res.w2 = word_t'(65535 - (scale_full(b, 65535 - d) + d));
			res.w3 = word_t'(65535 - (scale_full(c, 65535 - d) + d));
		end
		return res;
	endfunction

	task automatic report_mismatch(string field, word_t got, word_t want);
		$display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_pixels.push_back(convert_pixel(kind, word_0, word_1, word_2, word_3));
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t unexpected result transaction", $realtime);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (out_0 !== want.w0) report_mismatch("out_0", out_0, want.w0);
					if (out_1 !== want.w1) report_mismatch("out_1", out_1, want.w1);
					if (out_2 !== want.w2) report_mismatch("out_2", out_2, want.w2);
					if (out_3 !== want.w3) report_mismatch("out_3", out_3, want.w3);
				end
			end
		end
	end

endmodule

[tb/tb_argb_cmyk_converter_unit.sv]
// ----------------------------------------------------------------------------
// tb_argb_cmyk_converter_unit
// Drives directed and random pixels of both conversion kinds through the
// converter under random idling on both sides; the checker scores results.
// ----------------------------------------------------------------------------
module tb_argb_cmyk_converter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	typedef acc_pkg::word_t word_t;

	localparam word_t FULL         = acc_pkg::FULL;
	localparam logic  KIND_TO_CMYK = acc_pkg::KIND_TO_CMYK;
	localparam logic  KIND_TO_ARGB = acc_pkg::KIND_TO_ARGB;

	localparam int LATENCY     = 20;
	localparam int WATCH_LIMIT = 2000;
	localparam int RANDOM_N    = 500;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	logic  kind = 1'b0;
	word_t word_0 = '0, word_1 = '0, word_2 = '0, word_3 = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	word_t out_0, out_1, out_2, out_3;
	int    fail_count, pending;
	logic  quiet_phase = 1'b0;
	int    idle_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	argb_cmyk_converter_unit u_dut (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .word_0, .word_1, .word_2, .word_3,
		.out_valid, .out_stall, .out_0, .out_1, .out_2, .out_3
	);

	argb_cmyk_converter_checker u_checker (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .word_0, .word_1, .word_2, .word_3,
		.out_valid, .out_stall, .out_0, .out_1, .out_2, .out_3, .fail_count, .pending
	);

	// Stall the result side about 11 times in a hundred, never during the quiet phase.
	always @(posedge clk)
		out_stall <= !quiet_phase && ($urandom_range(99) < 11);

	// Watchdog: count cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Present one pixel, holding it until accepted, with a random gap in front.
	task automatic send_pixel(logic k_in, word_t a, word_t b, word_t c, word_t d);
		while (!quiet_phase && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k_in;
		word_0   <= a;
		word_1   <= b;
		word_2   <= c;
		word_3   <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Pick a channel value weighted toward the extremes.
	function automatic word_t pick_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return FULL;
			2: return word_t'($urandom_range(65535, 65280));
			default: return word_t'($urandom);
		endcase
	endfunction

	initial begin
		int    wait_cycles;
		word_t v;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, pure black, transparent and opaque, both kinds.
		send_pixel(KIND_TO_CMYK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_pixel(KIND_TO_CMYK, FULL, FULL, FULL, FULL);
		send_pixel(KIND_TO_CMYK, FULL, 16'h0000, 16'h0000, 16'h0000);
		send_pixel(KIND_TO_CMYK, 16'h0000, FULL, FULL, FULL);
		send_pixel(KIND_TO_CMYK, FULL, FULL, 16'h0000, 16'h0000);
		send_pixel(KIND_TO_CMYK, FULL, 16'h0000, FULL, 16'h0000);
		send_pixel(KIND_TO_CMYK, FULL, 16'h0000, 16'h0000, FULL);
		send_pixel(KIND_TO_CMYK, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
		send_pixel(KIND_TO_CMYK, FULL, 16'h0001, 16'h0002, 16'h0003);
		send_pixel(KIND_TO_CMYK, 16'h8000, 16'hAAAA, 16'h5555, 16'hFFFE);
		send_pixel(KIND_TO_CMYK, FULL, 16'h7FFF, 16'h8000, 16'hFFFE);
		send_pixel(KIND_TO_ARGB, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_pixel(KIND_TO_ARGB, FULL, FULL, FULL, FULL);
		send_pixel(KIND_TO_ARGB, FULL, FULL, FULL, 16'h0000);
		send_pixel(KIND_TO_ARGB, 16'h0000, 16'h0000, 16'h0000, FULL);
		send_pixel(KIND_TO_ARGB, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF);
		send_pixel(KIND_TO_ARGB, 16'h0001, FULL, 16'hFFFE, 16'h0001);
		send_pixel(KIND_TO_ARGB, 16'h1234, 16'h5678, 16'h9ABC, 16'hFFFE);

		// Random part; the middle stretch runs with no idling on either side.
		for (int i = 0; i < RANDOM_N; i++) begin
			quiet_phase = (i >= 200 && i < 300);
			v = pick_word();
			send_pixel(logic'($urandom_range(1)), v, pick_word(), pick_word(), pick_word());
		end
		quiet_phase = 1'b0;
		in_valid <= 1'b0;

		// Drain: wait for all expected results, then allow the pipeline latency.
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 5) @(posedge clk);
		if (pending == 0 && fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
